// ===== hdl/i2cmbs_pkg.sv =====
`timescale 1ns / 1ps

package i2cmbs_pkg;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd12;
  localparam logic [7:0] MSB_MASK        = 8'h80;
  localparam int unsigned BITS_PER_BYTE  = 8;
  localparam int unsigned IN_TDATA_W     = 16;
  localparam int unsigned OUT_TDATA_W    = 16;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_STOP  = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE        = 4'd0,
    ST_START_SDA   = 4'd1,
    ST_START_SCL   = 4'd2,
    ST_WR_HIGH     = 4'd3,
    ST_WR_LOW      = 4'd4,
    ST_WR_ACK_HIGH = 4'd5,
    ST_WR_ACK_LOW  = 4'd6,
    ST_RD_HIGH     = 4'd7,
    ST_RD_LOW      = 4'd8,
    ST_RD_ACK_HIGH = 4'd9,
    ST_RD_ACK_LOW  = 4'd10,
    ST_STOP_SDA    = 4'd11,
    ST_STOP_SCL    = 4'd12,
    ST_STOP_REL    = 4'd13
  } step_t;

  // one tick's input item
  typedef struct packed {
    logic       sda_in;
    logic       send_ack;
    logic [7:0] write_byte;
    logic [2:0] command;
  } tick_t;

  // result item, scl_out in the lowest bit
  typedef struct packed {
    logic       nack;
    logic [7:0] read_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } res_t;

endpackage

// ===== hdl/i2cmbs_seq.sv =====
`timescale 1ns / 1ps

module i2cmbs_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick_acc,
  input  i2cmbs_pkg::tick_t tick,
  input  logic [7:0]        phase_ticks,
  output i2cmbs_pkg::res_t  res
);

  i2cmbs_pkg::step_t step_r, step_nxt;
  logic [3:0] bit_index_r, bit_index_nxt;
  logic [7:0] delay_left_r, delay_left_nxt;
  logic [7:0] tx_shift_r, tx_shift_nxt;
  logic [7:0] rx_shift_r, rx_shift_nxt;
  logic [7:0] read_hold_r, read_hold_nxt;
  logic       nack_r, nack_nxt;
  logic       ack_req_r, ack_req_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       done;
  logic       fin;
  logic [7:0] plen;
  logic [3:0] bit_inc;
  logic [7:0] tx_shl;

  assign plen    = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
  assign bit_inc = bit_index_r + 4'd1;
  assign tx_shl  = {tx_shift_r[6:0], 1'b0};

  always_comb begin
    step_nxt       = step_r;
    bit_index_nxt  = bit_index_r;
    delay_left_nxt = delay_left_r;
    tx_shift_nxt   = tx_shift_r;
    rx_shift_nxt   = rx_shift_r;
    read_hold_nxt  = read_hold_r;
    nack_nxt       = nack_r;
    ack_req_nxt    = ack_req_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    done           = 1'b0;
    fin            = 1'b0;
    if (step_r == i2cmbs_pkg::ST_IDLE) begin
      unique case (i2cmbs_pkg::cmd_t'(tick.command))
        i2cmbs_pkg::CMD_START: begin
          scl_nxt        = 1'b1;
          sda_nxt        = 1'b1;
          step_nxt       = i2cmbs_pkg::ST_START_SDA;
          delay_left_nxt = plen;
        end
        i2cmbs_pkg::CMD_WRITE: begin
          tx_shift_nxt   = tick.write_byte;
          bit_index_nxt  = 4'd0;
          sda_nxt        = |(tick.write_byte & i2cmbs_pkg::MSB_MASK);
          step_nxt       = i2cmbs_pkg::ST_WR_HIGH;
          delay_left_nxt = plen;
        end
        i2cmbs_pkg::CMD_READ: begin
          ack_req_nxt    = tick.send_ack;
          rx_shift_nxt   = 8'd0;
          bit_index_nxt  = 4'd0;
          sda_nxt        = 1'b1;
          step_nxt       = i2cmbs_pkg::ST_RD_HIGH;
          delay_left_nxt = plen;
        end
        i2cmbs_pkg::CMD_STOP: begin
          step_nxt       = i2cmbs_pkg::ST_STOP_SDA;
          delay_left_nxt = plen;
        end
        default: ;
      endcase
    end else if (delay_left_r > 8'd1) begin
      delay_left_nxt = delay_left_r - 8'd1;
    end else begin
      unique case (step_r)
        i2cmbs_pkg::ST_START_SDA: begin
          sda_nxt  = 1'b0;
          step_nxt = i2cmbs_pkg::ST_START_SCL;
        end
        i2cmbs_pkg::ST_START_SCL: begin
          scl_nxt = 1'b0;
          fin     = 1'b1;
        end
        i2cmbs_pkg::ST_WR_HIGH: begin
          scl_nxt  = 1'b1;
          step_nxt = i2cmbs_pkg::ST_WR_LOW;
        end
        i2cmbs_pkg::ST_WR_LOW: begin
          scl_nxt       = 1'b0;
          tx_shift_nxt  = tx_shl;
          bit_index_nxt = bit_inc;
          if (bit_inc < 4'(i2cmbs_pkg::BITS_PER_BYTE)) begin
            sda_nxt  = |(tx_shl & i2cmbs_pkg::MSB_MASK);
            step_nxt = i2cmbs_pkg::ST_WR_HIGH;
          end else begin
            sda_nxt  = 1'b1;
            step_nxt = i2cmbs_pkg::ST_WR_ACK_HIGH;
          end
        end
        i2cmbs_pkg::ST_WR_ACK_HIGH: begin
          // ACK sampled just before SCL rises
          nack_nxt = tick.sda_in;
          scl_nxt  = 1'b1;
          step_nxt = i2cmbs_pkg::ST_WR_ACK_LOW;
        end
        i2cmbs_pkg::ST_WR_ACK_LOW: begin
          scl_nxt = 1'b0;
          fin     = 1'b1;
        end
        i2cmbs_pkg::ST_RD_HIGH: begin
          scl_nxt  = 1'b1;
          step_nxt = i2cmbs_pkg::ST_RD_LOW;
        end
        i2cmbs_pkg::ST_RD_LOW: begin
          rx_shift_nxt  = {rx_shift_r[6:0], tick.sda_in};
          scl_nxt       = 1'b0;
          bit_index_nxt = bit_inc;
          if (bit_inc < 4'(i2cmbs_pkg::BITS_PER_BYTE)) begin
            step_nxt = i2cmbs_pkg::ST_RD_HIGH;
          end else begin
            read_hold_nxt = {rx_shift_r[6:0], tick.sda_in};
            if (ack_req_r) begin
              sda_nxt = 1'b0;
            end
            step_nxt = i2cmbs_pkg::ST_RD_ACK_HIGH;
          end
        end
        i2cmbs_pkg::ST_RD_ACK_HIGH: begin
          scl_nxt  = 1'b1;
          step_nxt = i2cmbs_pkg::ST_RD_ACK_LOW;
        end
        i2cmbs_pkg::ST_RD_ACK_LOW: begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b1;
          fin     = 1'b1;
        end
        i2cmbs_pkg::ST_STOP_SDA: begin
          sda_nxt  = 1'b0;
          step_nxt = i2cmbs_pkg::ST_STOP_SCL;
        end
        i2cmbs_pkg::ST_STOP_SCL: begin
          scl_nxt  = 1'b1;
          step_nxt = i2cmbs_pkg::ST_STOP_REL;
        end
        i2cmbs_pkg::ST_STOP_REL: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
          fin     = 1'b1;
        end
        default: fin = 1'b1;
      endcase
      if (fin) begin
        step_nxt       = i2cmbs_pkg::ST_IDLE;
        delay_left_nxt = 8'd0;
        done           = 1'b1;
      end else begin
        delay_left_nxt = plen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= i2cmbs_pkg::ST_IDLE;
      bit_index_r  <= 4'd0;
      delay_left_r <= 8'd0;
      tx_shift_r   <= 8'd0;
      rx_shift_r   <= 8'd0;
      read_hold_r  <= 8'd0;
      nack_r       <= 1'b0;
      ack_req_r    <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
    end else if (tick_acc) begin
      step_r       <= step_nxt;
      bit_index_r  <= bit_index_nxt;
      delay_left_r <= delay_left_nxt;
      tx_shift_r   <= tx_shift_nxt;
      rx_shift_r   <= rx_shift_nxt;
      read_hold_r  <= read_hold_nxt;
      nack_r       <= nack_nxt;
      ack_req_r    <= ack_req_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
    end
  end

  always_comb begin
    res.scl_out   = scl_nxt;
    res.sda_out   = sda_nxt;
    res.busy_res  = (step_nxt != i2cmbs_pkg::ST_IDLE);
    res.done_res  = done;
    res.read_byte = read_hold_nxt;
    res.nack      = nack_nxt;
  end

  a_busy_has_delay: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != i2cmbs_pkg::ST_IDLE) |-> (delay_left_r != 8'd0))
    else $error("busy with zero delay count");

  a_idle_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == i2cmbs_pkg::ST_IDLE) |-> (delay_left_r == 8'd0))
    else $error("idle with pending delay");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_index_r <= 4'(i2cmbs_pkg::BITS_PER_BYTE))
    else $error("bit index past byte end");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_acc && res.done_res) |=> (step_r == i2cmbs_pkg::ST_IDLE))
    else $error("done without returning to idle");

endmodule

// ===== hdl/i2cmbs_out_reg.sv =====
`timescale 1ns / 1ps

module i2cmbs_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  i2cmbs_pkg::res_t res,
  output logic             free,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [i2cmbs_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic             valid_r, valid_nxt;
  i2cmbs_pkg::res_t res_r;

  // slot frees up in the same cycle the held item drains
  assign free      = !valid_r || out_tready;
  assign valid_nxt = load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {(i2cmbs_pkg::OUT_TDATA_W - $bits(i2cmbs_pkg::res_t))'(0), res_r};

endmodule

// ===== hdl/i2c_master_byte_sequencer_core.sv =====
`timescale 1ns / 1ps

// I2C master bit sequencer. Every input item is one bus timing tick and yields
// exactly one result item with the SCL/SDA levels to drive, busy, a done pulse,
// the last read byte and the last write's NACK. Commands (start, write, read,
// stop) are taken only when idle; each step of a sequence is spaced by
// cfg phase_ticks ticks (0 acts as 1, reset 12). Throughput is one item per
// clock unless the output stalls: the sequencer state updates in the cycle an
// item is accepted and the result lands in a single output register for the
// next cycle. in_tready drops only while that register holds an untaken item.
module i2c_master_byte_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] command, [10:3] write_byte, [11] send_ack, [12] sda_in
  input  logic [i2cmbs_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] read_byte, [12] nack
  output logic [i2cmbs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  logic              in_acc;
  logic              free;
  logic [7:0]        phase_ticks_r;
  i2cmbs_pkg::tick_t tick;
  i2cmbs_pkg::res_t  res;

  assign in_tready = free;
  assign in_acc    = in_tvalid && free;
  assign tick      = i2cmbs_pkg::tick_t'(in_tdata[$bits(i2cmbs_pkg::tick_t)-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= i2cmbs_pkg::PHASE_TICKS_RST;
    end else if (cfg_we) begin
      phase_ticks_r <= cfg_wdata;
    end
  end

  i2cmbs_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_acc    (in_acc),
    .tick        (tick),
    .phase_ticks (phase_ticks_r),
    .res         (res)
  );

  i2cmbs_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_acc),
    .res        (res),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
